@@ sv/lsp_pkg.sv @@
// Shared types, constants and helper functions of the line segment polar form block.
package lsp_pkg;

  // Internal datapath width of the CORDIC unit and its shift count width.
  localparam int DW  = 64;
  localparam int SHW = 6;

  // Default configuration of the top level.
  localparam int COORD_BITS_DEF   = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle constants; CORDIC angles are Q30.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic signed [DW-1:0] PI30 =
    signed'((PI_Q60 + (64'd1 << 29)) >> 30);
  localparam logic signed [DW-1:0] HALF_PI30 =
    signed'((PI_Q60 + (64'd1 << 30)) >> 31);

  // Gain compensation 0.60725293500888 in Q30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // Pi rounded to the given number of fraction bits.
  function automatic logic signed [DW-1:0] pi_f(int frac);
    logic [63:0] r;
    r = (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    return signed'(r);
  endfunction

  // Pi/2 rounded to the given number of fraction bits.
  function automatic logic signed [DW-1:0] half_pi_f(int frac);
    logic [63:0] r;
    r = (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
    return signed'(r);
  endfunction

  // Arctangent of 2^-i in Q30.
  function automatic logic [29:0] atan_q30(logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Signed saturation to [lo, hi].
  function automatic logic signed [DW-1:0] clamp_s(logic signed [DW-1:0] v,
                                                   logic signed [DW-1:0] lo,
                                                   logic signed [DW-1:0] hi);
    logic signed [DW-1:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

  // Request to the CORDIC unit.
  typedef struct packed {
    logic                 start;
    logic                 vec_mode;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] ang;
  } lsp_cmd_t;

  // Answer of the CORDIC unit.
  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic [SHW-1:0]       sh;
  } lsp_res_t;

endpackage

@@ sv/lsp_cordic.sv @@
// Iterative CORDIC unit with normalization, gain compensation and scale back.
module lsp_cordic #(
  parameter int CORDIC_STEPS = lsp_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lsp_pkg::lsp_cmd_t cmd,
  output lsp_pkg::lsp_res_t res
);
  import lsp_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    C_IDLE, C_NORM, C_PRE, C_ITER, C_GHI, C_GLO, C_GSUM, C_SCALE
  } cstate_t;

  cstate_t              state_r;
  logic                 mode_r;
  logic                 oy_pos_r;
  logic                 gsel_r;
  logic                 done_r;
  logic signed [DW-1:0] x_r, y_r, z_r;
  logic [SHW-1:0]       s_r;
  logic [IW-1:0]        i_r;
  logic [63:0]          hi_r, lo_r;

  logic [63:0]          ax, ay;
  logic                 norm_done, shift8;
  logic signed [DW-1:0] sx, sy, at;
  logic                 up;
  logic signed [DW-1:0] it_x, it_y, it_z;
  logic signed [DW-1:0] gv;
  logic [63:0]          gm;
  logic [33:0]          mul_a;
  logic [63:0]          mul_p;
  logic [63:0]          gsum;
  logic signed [DW-1:0] gval;
  logic [63:0]          rnd_add;
  logic signed [DW-1:0] sc_x, sc_y;
  logic [63:0]          cx_abs, cy_abs;

  // Magnitudes of the working vector and of the request.
  always_comb begin
    ax     = x_r[DW-1] ? 64'(-x_r) : 64'(x_r);
    ay     = y_r[DW-1] ? 64'(-y_r) : 64'(y_r);
    cx_abs = cmd.x[DW-1] ? 64'(-cmd.x) : 64'(cmd.x);
    cy_abs = cmd.y[DW-1] ? 64'(-cmd.y) : 64'(cmd.y);
  end

  // Normalization: larger component brought into [2^57, 2^58).
  assign norm_done = (|ax[63:57]) | (|ay[63:57]);
  assign shift8    = ~((|ax[63:49]) | (|ay[63:49]));

  // One micro-rotation.
  always_comb begin
    sx = x_r >>> i_r;
    sy = y_r >>> i_r;
    at = DW'({1'b0, atan_q30(5'(i_r))});
    up = mode_r ? (y_r > 0) : (z_r < 0);
    if (up) begin
      it_x = x_r + sy;
      it_y = y_r - sx;
      it_z = z_r + at;
    end else begin
      it_x = x_r - sy;
      it_y = y_r + sx;
      it_z = z_r - at;
    end
  end

  // Gain compensation on the shared multiplier, high and low halves in turn.
  always_comb begin
    gv    = gsel_r ? y_r : x_r;
    gm    = gv[DW-1] ? 64'(-gv) : 64'(gv);
    mul_a = (state_r == C_GHI) ? gm[63:30] : {4'd0, gm[29:0]};
    mul_p = mul_a * GAIN_Q30;
    gsum  = hi_r + ((lo_r + (64'd1 << 29)) >> 30);
    gval  = gv[DW-1] ? -signed'(gsum) : signed'(gsum);
  end

  // Scale back with round half up.
  always_comb begin
    rnd_add = (64'd1 << s_r) >> 1;
    sc_x    = (x_r + signed'(rnd_add)) >>> s_r;
    sc_y    = (y_r + signed'(rnd_add)) >>> s_r;
  end

  // Sequencer and registers; the done pulse is only ever high while idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (cmd.start) begin
            mode_r   <= cmd.vec_mode;
            s_r      <= '0;
            i_r      <= '0;
            gsel_r   <= 1'b0;
            y_r      <= cmd.y;
            oy_pos_r <= (cmd.y > 0);
            if (cmd.vec_mode) begin
              if (cmd.y == 0) begin
                x_r    <= signed'(cx_abs);
                z_r    <= cmd.x[DW-1] ? PI30 : '0;
                done_r <= 1'b1;
              end else if (cmd.x == 0) begin
                x_r    <= signed'(cy_abs);
                z_r    <= (cmd.y > 0) ? HALF_PI30 : -HALF_PI30;
                done_r <= 1'b1;
              end else begin
                x_r     <= cmd.x;
                z_r     <= '0;
                done_r  <= 1'b0;
                state_r <= C_NORM;
              end
            end else begin
              x_r <= cmd.x;
              z_r <= cmd.ang;
              if (cmd.x == 0 && cmd.y == 0) begin
                done_r <= 1'b1;
              end else begin
                done_r  <= 1'b0;
                state_r <= C_NORM;
              end
            end
          end else begin
            done_r <= 1'b0;
          end
        end
        C_NORM: begin
          if (norm_done) begin
            state_r <= C_PRE;
          end else if (shift8) begin
            x_r <= x_r <<< 8;
            y_r <= y_r <<< 8;
            s_r <= s_r + SHW'(8);
          end else begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
            s_r <= s_r + SHW'(1);
          end
        end
        C_PRE: begin
          // Fold the vector or the angle into the right half plane.
          if (mode_r) begin
            if (x_r < 0) begin
              x_r <= -x_r;
              y_r <= -y_r;
              z_r <= oy_pos_r ? PI30 : -PI30;
            end
          end else if (z_r > HALF_PI30) begin
            x_r <= -x_r;
            y_r <= -y_r;
            z_r <= z_r - PI30;
          end else if (z_r < -HALF_PI30) begin
            x_r <= -x_r;
            y_r <= -y_r;
            z_r <= z_r + PI30;
          end
          state_r <= C_ITER;
        end
        C_ITER: begin
          x_r <= it_x;
          y_r <= it_y;
          z_r <= it_z;
          if (i_r == LAST) begin
            state_r <= C_GHI;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
        C_GHI: begin
          hi_r    <= mul_p;
          state_r <= C_GLO;
        end
        C_GLO: begin
          lo_r    <= mul_p;
          state_r <= C_GSUM;
        end
        C_GSUM: begin
          if (!gsel_r) begin
            x_r <= gval;
            if (mode_r) begin
              done_r  <= 1'b1;
              state_r <= C_IDLE;
            end else begin
              gsel_r  <= 1'b1;
              state_r <= C_GHI;
            end
          end else begin
            y_r     <= gval;
            state_r <= C_SCALE;
          end
        end
        C_SCALE: begin
          x_r     <= sc_x;
          y_r     <= sc_y;
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.x    = x_r;
  assign res.y    = y_r;
  assign res.z    = z_r;
  assign res.sh   = s_r;

endmodule

@@ sv/line_segment_polar_form.sv @@
// Top level: line segment held in redundant polar form, with load and rotate commands.
//
// One item at a time: a load takes two CORDIC runs (atan2 and length of the
// direction, then the centre turned by -theta), a rotate takes three runs
// (start, end and centre points) plus an angle wrapping step. A CORDIC run
// goes through the start, normalization, one fold, CORDIC_STEPS
// micro-rotations, high, low and sum multiplier steps per gain-corrected
// component (x only in vectoring mode) and a scale step in rotation mode; it
// ends early for zero vectors and, in vectoring mode, for axis-aligned ones.
// All runs use the shared CORDIC unit. The input is stalled while an item is
// in work; the finished result sits in an output register, so the next item
// may enter while that result is still stalled.
module line_segment_polar_form #(
  parameter int COORD_BITS   = lsp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS    = lsp_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = lsp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  input  logic signed [FRAC_BITS+2:0]  in_rotate_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_start_x,
  output logic signed [COORD_BITS-1:0] out_start_y,
  output logic signed [COORD_BITS-1:0] out_finish_x,
  output logic signed [COORD_BITS-1:0] out_finish_y,
  output logic signed [COORD_BITS-1:0] out_centre_x,
  output logic signed [COORD_BITS-1:0] out_centre_y,
  output logic signed [FRAC_BITS+3:0]  out_normal_angle,
  output logic signed [FRAC_BITS+3:0]  out_direction_angle,
  output logic        [COORD_BITS-2:0] out_perp_distance,
  output logic signed [COORD_BITS-1:0] out_tangent_offset,
  output logic        [COORD_BITS-2:0] out_half_length
);
  import lsp_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int AW = FRAC_BITS + 4;
  localparam int RW = FRAC_BITS + 3;
  localparam int WW = FRAC_BITS + 6;
  localparam int QS = 30 - FRAC_BITS;
  localparam logic signed [DW-1:0] COORD_MAX = (64'sd1 <<< (C - 1)) - 64'sd1;
  localparam logic signed [DW-1:0] COORD_MIN = -COORD_MAX - 64'sd1;
  localparam logic signed [DW-1:0] PI_F      = pi_f(FRAC_BITS);
  localparam logic signed [DW-1:0] HALF_PI_F = half_pi_f(FRAC_BITS);
  localparam logic signed [DW-1:0] TWO_PI_F  = PI_F + PI_F;
  localparam logic signed [DW-1:0] Q_RND     = 64'sd1 <<< (QS - 1);
  localparam logic signed [WW-1:0] TWO_PI_W  = WW'(TWO_PI_F);

  typedef enum logic [3:0] {
    T_IDLE, T_VEC, T_VWAIT, T_ROT, T_RWAIT, T_PSTART, T_PWAIT, T_AWRAP, T_OUT
  } tstate_t;

  tstate_t              state_r;
  logic signed [C-1:0]  xs_r, ys_r, xe_r, ye_r, xc_r, yc_r;
  logic signed [AW-1:0] alpha_r, theta_r;
  logic signed [C-1:0]  c_r, d_r, h_r;
  logic signed [DW-1:0] mag_r;
  logic [SHW-1:0]       sh_r;
  logic signed [RW-1:0] rot_a_r;
  logic [1:0]           k_r;
  logic                 out_valid_r;

  logic signed [C-1:0]  o_sx_r, o_sy_r, o_ex_r, o_ey_r, o_cx_r, o_cy_r, o_d_r;
  logic signed [AW-1:0] o_alpha_r, o_theta_r;
  logic [C-2:0]         o_c_r, o_h_r;

  lsp_cmd_t             cmd;
  lsp_res_t             res;
  logic                 accept;
  logic signed [C:0]    sum_x, sum_y;
  logic signed [DW-1:0] pair_x, pair_y;
  logic signed [DW-1:0] rot_x_sat, rot_y_sat;
  logic signed [DW-1:0] th_rnd, th_wrap;
  logic                 flip;
  logic signed [DW-1:0] al_raw, al_wrap;
  logic signed [DW-1:0] c_abs, c_sat, d_sat, h_rnd, h_sat;
  logic [SHW-1:0]       h_sh;
  logic [63:0]          h_add;
  logic signed [WW-1:0] wa0, wa1, wa2, wa3, wa4;
  logic signed [WW-1:0] wt0, wt1, wt2, wt3, wt4;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != T_IDLE);

  // Centre of the incoming segment, rounded toward minus infinity.
  always_comb begin
    sum_x = (C+1)'(in_x_start) + (C+1)'(in_x_end);
    sum_y = (C+1)'(in_y_start) + (C+1)'(in_y_end);
  end

  // Point pair fed to the CORDIC unit during a rotate command.
  always_comb begin
    case (k_r)
      2'd0: begin
        pair_x = DW'(xs_r);
        pair_y = DW'(ys_r);
      end
      2'd1: begin
        pair_x = DW'(xe_r);
        pair_y = DW'(ye_r);
      end
      default: begin
        pair_x = DW'(xc_r);
        pair_y = DW'(yc_r);
      end
    endcase
  end

  // Requests to the CORDIC unit.
  always_comb begin
    cmd.start    = 1'b0;
    cmd.vec_mode = 1'b0;
    cmd.x        = pair_x;
    cmd.y        = pair_y;
    cmd.ang      = DW'(rot_a_r) <<< QS;
    case (state_r)
      T_VEC: begin
        cmd.start    = 1'b1;
        cmd.vec_mode = 1'b1;
        cmd.x        = DW'(xe_r) - DW'(xs_r);
        cmd.y        = DW'(ye_r) - DW'(ys_r);
      end
      T_ROT: begin
        cmd.start = 1'b1;
        cmd.x     = DW'(xc_r);
        cmd.y     = DW'(yc_r);
        cmd.ang   = -(DW'(theta_r) <<< QS);
      end
      T_PSTART: begin
        cmd.start = 1'b1;
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  lsp_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lsp_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .res  (res)
  );

  // Direction angle from the vectoring result, wrapped to (-pi, pi].
  always_comb begin
    th_rnd = (res.z + Q_RND) >>> QS;
    if (th_rnd > PI_F) begin
      th_wrap = th_rnd - TWO_PI_F;
    end else if (th_rnd <= -PI_F) begin
      th_wrap = th_rnd + TWO_PI_F;
    end else begin
      th_wrap = th_rnd;
    end
  end

  // Normal angle, distances and half length once the centre is turned by -theta.
  always_comb begin
    if (xc_r == 0 && yc_r == 0) begin
      flip = theta_r < 0;
    end else begin
      flip = res.y > 0;
    end
    al_raw = DW'(theta_r) - HALF_PI_F + (flip ? PI_F : 64'sd0);
    if (al_raw > PI_F) begin
      al_wrap = al_raw - TWO_PI_F;
    end else if (al_raw <= -PI_F) begin
      al_wrap = al_raw + TWO_PI_F;
    end else begin
      al_wrap = al_raw;
    end
    c_abs = res.y[DW-1] ? -res.y : res.y;
    c_sat = clamp_s(c_abs, 64'sd0, COORD_MAX);
    d_sat = clamp_s(res.x, COORD_MIN, COORD_MAX);
    h_sh  = sh_r + SHW'(1);
    h_add = (64'd1 << h_sh) >> 1;
    h_rnd = (mag_r + signed'(h_add)) >>> h_sh;
    h_sat = clamp_s(h_rnd, 64'sd0, COORD_MAX);
  end

  // Rotated point saturated to the coordinate range.
  always_comb begin
    rot_x_sat = clamp_s(res.x, COORD_MIN, COORD_MAX);
    rot_y_sat = clamp_s(res.y, COORD_MIN, COORD_MAX);
  end

  // Angles after a rotate command, wrapped to [0, 2pi).
  always_comb begin
    wa0 = WW'(alpha_r) + WW'(rot_a_r);
    wa1 = (wa0 < 0) ? wa0 + TWO_PI_W : wa0;
    wa2 = (wa1 < 0) ? wa1 + TWO_PI_W : wa1;
    wa3 = (wa2 >= TWO_PI_W) ? wa2 - TWO_PI_W : wa2;
    wa4 = (wa3 >= TWO_PI_W) ? wa3 - TWO_PI_W : wa3;
    wt0 = WW'(theta_r) + WW'(rot_a_r);
    wt1 = (wt0 < 0) ? wt0 + TWO_PI_W : wt0;
    wt2 = (wt1 < 0) ? wt1 + TWO_PI_W : wt1;
    wt3 = (wt2 >= TWO_PI_W) ? wt2 - TWO_PI_W : wt2;
    wt4 = (wt3 >= TWO_PI_W) ? wt3 - TWO_PI_W : wt3;
  end

  // Sequencer, stored line and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      xs_r        <= '0;
      ys_r        <= '0;
      xe_r        <= '0;
      ye_r        <= '0;
      xc_r        <= '0;
      yc_r        <= '0;
      alpha_r     <= '0;
      theta_r     <= '0;
      c_r         <= '0;
      d_r         <= '0;
      h_r         <= '0;
    end else begin
      // A transferred result frees the output register unless a new one lands.
      if (out_valid_r && !out_stall && state_r != T_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            if (in_opcode) begin
              rot_a_r <= in_rotate_angle;
              k_r     <= 2'd0;
              state_r <= T_PSTART;
            end else begin
              xs_r    <= in_x_start;
              ys_r    <= in_y_start;
              xe_r    <= in_x_end;
              ye_r    <= in_y_end;
              xc_r    <= sum_x[C:1];
              yc_r    <= sum_y[C:1];
              state_r <= T_VEC;
            end
          end
        end
        T_VEC: begin
          state_r <= T_VWAIT;
        end
        T_VWAIT: begin
          if (res.done) begin
            theta_r <= AW'(th_wrap);
            mag_r   <= res.x;
            sh_r    <= res.sh;
            state_r <= T_ROT;
          end
        end
        T_ROT: begin
          state_r <= T_RWAIT;
        end
        T_RWAIT: begin
          if (res.done) begin
            alpha_r <= AW'(al_wrap);
            c_r     <= C'(c_sat);
            d_r     <= C'(d_sat);
            h_r     <= C'(h_sat);
            state_r <= T_OUT;
          end
        end
        T_PSTART: begin
          state_r <= T_PWAIT;
        end
        T_PWAIT: begin
          if (res.done) begin
            case (k_r)
              2'd0: begin
                xs_r <= C'(rot_x_sat);
                ys_r <= C'(rot_y_sat);
              end
              2'd1: begin
                xe_r <= C'(rot_x_sat);
                ye_r <= C'(rot_y_sat);
              end
              default: begin
                xc_r <= C'(rot_x_sat);
                yc_r <= C'(rot_y_sat);
              end
            endcase
            if (k_r == 2'd2) begin
              state_r <= T_AWRAP;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= T_PSTART;
            end
          end
        end
        T_AWRAP: begin
          alpha_r <= AW'(wa4);
          theta_r <= AW'(wt4);
          state_r <= T_OUT;
        end
        T_OUT: begin
          // Snapshot the stored line once the output register is free.
          if (!out_valid_r || !out_stall) begin
            o_sx_r      <= xs_r;
            o_sy_r      <= ys_r;
            o_ex_r      <= xe_r;
            o_ey_r      <= ye_r;
            o_cx_r      <= xc_r;
            o_cy_r      <= yc_r;
            o_alpha_r   <= alpha_r;
            o_theta_r   <= theta_r;
            o_c_r       <= c_r[C-2:0];
            o_d_r       <= d_r;
            o_h_r       <= h_r[C-2:0];
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_start_x         = o_sx_r;
  assign out_start_y         = o_sy_r;
  assign out_finish_x        = o_ex_r;
  assign out_finish_y        = o_ey_r;
  assign out_centre_x        = o_cx_r;
  assign out_centre_y        = o_cy_r;
  assign out_normal_angle    = o_alpha_r;
  assign out_direction_angle = o_theta_r;
  assign out_perp_distance   = o_c_r;
  assign out_tangent_offset  = o_d_r;
  assign out_half_length     = o_h_r;

endmodule

@@ sv/lsp_checker.sv @@
// Port-level checks of the line segment polar form block, bound to the top level.
module lsp_checker #(
  parameter int COORD_BITS = lsp_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_start_x
);

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transfer");

  // A result only appears at the end of work on an item.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // A stalled result stays valid and unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_start_x)))
    else $error("stalled result changed or dropped");

endmodule

bind line_segment_polar_form lsp_checker #(
  .COORD_BITS(COORD_BITS)
) u_lsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_start_x(out_start_x)
);
